// ----- hw/rtl/tgg_pkg.sv -----
package tgg_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MAX_STROKES = 20;

    localparam int TYPE_BITS   = 16;
    localparam int CODE_BITS   = 16;
    localparam int VALUE_BITS  = 32;
    localparam int ZONE_BITS   = 4;
    localparam int COUNT_BITS  = 5;
    localparam int SPAN_BITS   = 16;
    localparam int BAND_BITS   = 2;

    localparam int IN_DATA_BITS   = 64;
    localparam int OUT_FIELD_BITS = ZONE_BITS + COUNT_BITS + 1 + 2 * SPAN_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    localparam int WIDE_BITS = (COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [SPAN_BITS-1:0]  SPAN_MAX  = '1;

    // ceil(2^(COORD_BITS+1) / 3): exact quotient by three for any coordinate-wide value
    localparam logic [COORD_BITS-1:0] RECIP3 =
        COORD_BITS'(((64'd1 << (COORD_BITS + 1)) + 64'd2) / 64'd3);

    localparam logic [TYPE_BITS-1:0] EV_SYNC       = '0;
    localparam logic [CODE_BITS-1:0] CODE_X        = 16'd0;
    localparam logic [CODE_BITS-1:0] CODE_Y        = 16'd1;
    localparam logic [CODE_BITS-1:0] CODE_PRESSURE = 16'd24;

    localparam logic [BAND_BITS-1:0] BAND_LOW  = 2'd0;
    localparam logic [BAND_BITS-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_BITS-1:0] BAND_HIGH = 2'd2;

    typedef struct packed {
        logic                  is_sync;
        logic                  is_x;
        logic                  is_y;
        logic                  is_release;
        logic [COORD_BITS-1:0] coord;
    } item_t;

    typedef struct packed {
        logic [ZONE_BITS-1:0]  zone;
        logic                  gesture_end;
        logic [COUNT_BITS-1:0] stroke_count;
        logic                  overflow;
        logic [SPAN_BITS-1:0]  x_span;
        logic [SPAN_BITS-1:0]  y_span;
    } res_t;

    function automatic logic [COORD_BITS-1:0] span_of(
        input logic [COORD_BITS-1:0] lo,
        input logic [COORD_BITS-1:0] hi
    );
        return (hi >= lo) ? (hi - lo) : '0;
    endfunction

    function automatic logic [SPAN_BITS-1:0] sat_span(input logic [COORD_BITS-1:0] s);
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(s);
        if (wide > WIDE_BITS'(SPAN_MAX)) begin
            return SPAN_MAX;
        end
        return wide[SPAN_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] div3(input logic [COORD_BITS-1:0] n);
        logic [2*COORD_BITS-1:0] prod;
        prod = {{COORD_BITS{1'b0}}, n} * {{COORD_BITS{1'b0}}, RECIP3};
        return {1'b0, prod[2*COORD_BITS-1:COORD_BITS+1]};
    endfunction

    function automatic logic [BAND_BITS-1:0] band(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] lo,
        input logic [COORD_BITS-1:0] hi
    );
        logic [COORD_BITS-1:0] gap;
        logic [COORD_BITS-1:0] off;
        logic [COORD_BITS-1:0] third;
        logic [COORD_BITS-1:0] rem;
        logic [COORD_BITS-1:0] two_thirds;
        gap   = span_of(lo, hi);
        off   = (p > lo) ? (p - lo) : '0;
        off   = (off > gap) ? gap : off;
        third = div3(gap);
        rem   = gap - (third + (third << 1));
        two_thirds = (third << 1) + COORD_BITS'(rem[1:0] == 2'd2);
        if (off <= third) begin
            return BAND_LOW;
        end
        if (off <= two_thirds) begin
            return BAND_MID;
        end
        return BAND_HIGH;
    endfunction

endpackage

// ----- hw/rtl/tgg_in_stage.sv -----
module tgg_in_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tgg_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic                                advance,
    output logic                                item_vld,
    output tgg_pkg::item_t                      item
);
    import tgg_pkg::*;

    logic                   vld_reg;
    logic                   vld_next;
    item_t                  item_reg;
    item_t                  item_next;
    logic [TYPE_BITS-1:0]   ev_type;
    logic [CODE_BITS-1:0]   ev_code;
    logic [VALUE_BITS-1:0]  ev_value;
    logic                   take;

    assign ev_type  = s_tdata[TYPE_BITS-1:0];
    assign ev_code  = s_tdata[TYPE_BITS+CODE_BITS-1:TYPE_BITS];
    assign ev_value = s_tdata[TYPE_BITS+CODE_BITS+VALUE_BITS-1:TYPE_BITS+CODE_BITS];

    assign s_tready = !vld_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        item_next.is_sync    = (ev_type == EV_SYNC);
        item_next.is_x       = (ev_type != EV_SYNC) && (ev_code == CODE_X);
        item_next.is_y       = (ev_type != EV_SYNC) && (ev_code == CODE_Y);
        item_next.is_release = (ev_type != EV_SYNC) && (ev_code == CODE_PRESSURE)
                               && (ev_value == '0);
        if (ev_value[VALUE_BITS-1]) begin
            item_next.coord = '0;
        end else if (ev_value > VALUE_BITS'(COORD_MAX)) begin
            item_next.coord = COORD_MAX;
        end else begin
            item_next.coord = ev_value[COORD_BITS-1:0];
        end
    end

    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (advance) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// ----- hw/rtl/tgg_tracker.sv -----
module tgg_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                mode,
    input  logic                item_vld,
    input  tgg_pkg::item_t      item,
    input  logic                advance,
    output logic                res_vld,
    output tgg_pkg::res_t       res
);
    import tgg_pkg::*;

    logic [COORD_BITS-1:0] pending_x_reg, pending_x_next;
    logic [COORD_BITS-1:0] pending_y_reg, pending_y_next;
    logic                  seen_x_reg, seen_x_next;
    logic                  seen_y_reg, seen_y_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  pos_valid_reg, pos_valid_next;
    logic [ZONE_BITS-1:0]  current_zone_reg, current_zone_next;
    logic [COUNT_BITS-1:0] zone_count_reg, zone_count_next;
    logic                  over_flag_reg, over_flag_next;
    logic [COORD_BITS-1:0] min_x_reg, min_x_next;
    logic [COORD_BITS-1:0] max_x_reg, max_x_next;
    logic [COORD_BITS-1:0] min_y_reg, min_y_next;
    logic [COORD_BITS-1:0] max_y_reg, max_y_next;

    logic                  fire;
    logic                  pair_done;
    logic [COORD_BITS-1:0] sel_x;
    logic [COORD_BITS-1:0] sel_y;
    logic [BAND_BITS-1:0]  band_x;
    logic [BAND_BITS-1:0]  band_y;
    logic [ZONE_BITS-1:0]  zone_calc;

    assign fire      = item_vld && advance;
    assign pair_done = seen_x_reg && seen_y_reg;
    assign sel_x     = pair_done ? pending_x_reg : pos_x_reg;
    assign sel_y     = pair_done ? pending_y_reg : pos_y_reg;
    assign band_x    = band(sel_x, min_x_reg, max_x_reg);
    assign band_y    = band(sel_y, min_y_reg, max_y_reg);
    assign zone_calc = {2'b00, band_x} + {1'b0, band_x, 1'b0} + {2'b00, band_y}
                       + ZONE_BITS'(1);

    always_comb begin
        pending_x_next    = pending_x_reg;
        pending_y_next    = pending_y_reg;
        seen_x_next       = seen_x_reg;
        seen_y_next       = seen_y_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        pos_valid_next    = pos_valid_reg;
        current_zone_next = current_zone_reg;
        zone_count_next   = zone_count_reg;
        over_flag_next    = over_flag_reg;
        min_x_next        = min_x_reg;
        max_x_next        = max_x_reg;
        min_y_next        = min_y_reg;
        max_y_next        = max_y_reg;

        res_vld          = 1'b0;
        res.zone         = '0;
        res.gesture_end  = 1'b0;
        res.stroke_count = zone_count_reg;
        res.overflow     = over_flag_reg;
        res.x_span       = sat_span(span_of(min_x_reg, max_x_reg));
        res.y_span       = sat_span(span_of(min_y_reg, max_y_reg));

        if (fire) begin
            priority if (!item.is_sync) begin
                priority if (item.is_x) begin
                    pending_x_next = item.coord;
                    seen_x_next    = 1'b1;
                end else if (item.is_y) begin
                    pending_y_next = item.coord;
                    seen_y_next    = 1'b1;
                end else if (item.is_release) begin
                    res_vld           = 1'b1;
                    res.gesture_end   = 1'b1;
                    pending_x_next    = '0;
                    pending_y_next    = '0;
                    seen_x_next       = 1'b0;
                    seen_y_next       = 1'b0;
                    pos_x_next        = '0;
                    pos_y_next        = '0;
                    pos_valid_next    = 1'b0;
                    current_zone_next = '0;
                    zone_count_next   = '0;
                    over_flag_next    = 1'b0;
                end else begin
                end
            end else if (!mode) begin
                if (seen_x_reg) begin
                    if (pending_x_reg > max_x_reg) begin
                        max_x_next = pending_x_reg;
                    end
                    if (pending_x_reg < min_x_reg) begin
                        min_x_next = pending_x_reg;
                    end
                end
                if (seen_y_reg) begin
                    if (pending_y_reg > max_y_reg) begin
                        max_y_next = pending_y_reg;
                    end
                    if (pending_y_reg < min_y_reg) begin
                        min_y_next = pending_y_reg;
                    end
                end
                seen_x_next = 1'b0;
                seen_y_next = 1'b0;
            end else begin
                seen_x_next = 1'b0;
                seen_y_next = 1'b0;
                if (pair_done) begin
                    pos_x_next     = pending_x_reg;
                    pos_y_next     = pending_y_reg;
                    pos_valid_next = 1'b1;
                end
                if ((pos_valid_reg || pair_done) && (zone_calc != current_zone_reg)) begin
                    current_zone_next = zone_calc;
                    if (zone_count_reg >= COUNT_BITS'(MAX_STROKES)) begin
                        over_flag_next = 1'b1;
                    end else begin
                        zone_count_next  = zone_count_reg + COUNT_BITS'(1);
                        res_vld          = 1'b1;
                        res.zone         = zone_calc;
                        res.stroke_count = zone_count_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_x_reg    <= '0;
            pending_y_reg    <= '0;
            seen_x_reg       <= 1'b0;
            seen_y_reg       <= 1'b0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            pos_valid_reg    <= 1'b0;
            current_zone_reg <= '0;
            zone_count_reg   <= '0;
            over_flag_reg    <= 1'b0;
            min_x_reg        <= COORD_MAX;
            max_x_reg        <= '0;
            min_y_reg        <= COORD_MAX;
            max_y_reg        <= '0;
        end else begin
            pending_x_reg    <= pending_x_next;
            pending_y_reg    <= pending_y_next;
            seen_x_reg       <= seen_x_next;
            seen_y_reg       <= seen_y_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            pos_valid_reg    <= pos_valid_next;
            current_zone_reg <= current_zone_next;
            zone_count_reg   <= zone_count_next;
            over_flag_reg    <= over_flag_next;
            min_x_reg        <= min_x_next;
            max_x_reg        <= max_x_next;
            min_y_reg        <= min_y_next;
            max_y_reg        <= max_y_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        zone_count_reg <= COUNT_BITS'(MAX_STROKES))
        else $error("stroke count above limit");

    a_over_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        over_flag_reg |-> (zone_count_reg == COUNT_BITS'(MAX_STROKES)))
        else $error("overflow flagged below stroke limit");

    a_zone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_vld && !res.gesture_end) |-> ((res.zone != '0) && (res.zone <= ZONE_BITS'(9))))
        else $error("zone result out of range");

    a_no_pos_no_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        !pos_valid_reg |-> ((current_zone_reg == '0) && (zone_count_reg == '0)))
        else $error("zone state without a position");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_vld && !res.gesture_end) |=> (zone_count_reg == $past(zone_count_reg) + COUNT_BITS'(1)))
        else $error("zone result without count step");

endmodule

// ----- hw/rtl/touch_grid_gesture_tracker.sv -----
// Touchpad gesture tracker. Each s_ transaction carries one input event; sync events
// (type 0) close a report. With mode 0 a sync widens the calibrated X/Y extents; with
// mode 1 a sync that has a position places it in a 3x3 grid of the calibrated span and
// sends the zone (1..9) when it changes, up to MAX_STROKES zones per gesture. A pressure
// release (code 24, value 0) sends an end result with m_tlast high, the stroke count,
// the overflow flag and both spans, then clears the gesture. One event is taken every
// clock cycle: the event is decoded and its coordinate clamped into an input register,
// then the tracker logic (span, a constant multiply for the thirds of the span,
// compares) fills the result register, which drives m_. Input stalls only while the
// result register holds a result that m_tready has not taken. Write cfg_wr_data
// (mode) only while no event is in flight.
module touch_grid_gesture_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // event_type[15:0], event_code[31:16], event_value[63:32]
    input  logic [tgg_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // zone[3:0], stroke_count[8:4], overflow[9], x_span[25:10], y_span[41:26], zeros above
    output logic [tgg_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                m_tlast
);
    import tgg_pkg::*;

    logic   mode_reg;
    logic   out_vld_reg;
    logic   out_vld_next;
    res_t   out_reg;
    logic   advance;
    logic   item_vld;
    item_t  item;
    logic   res_vld;
    res_t   res;

    assign advance = !out_vld_reg || m_tready;

    tgg_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    tgg_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (mode_reg),
        .item_vld (item_vld),
        .item     (item),
        .advance  (advance),
        .res_vld  (res_vld),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (advance) begin
            out_vld_next = item_vld && res_vld;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_vld && res_vld) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_reg.gesture_end;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_reg.y_span, out_reg.x_span,
                       out_reg.overflow, out_reg.stroke_count, out_reg.zone};

endmodule
